// ----- hw/rtl/frustum_cull_test_assert.svh -----
// ---------------------------------------------------------------------------
// frustum_cull_test_assert.svh - assertion macros
// Wraps concurrent assertions so that they can be left out of a build.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TEST_ASSERT_SVH
`define FRUSTUM_CULL_TEST_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clk, quiet during rst.
`define FCT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frustum_cull_test: assertion failed");

// Next-cycle implication, clocked on clk, quiet during rst.
`define FCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frustum_cull_test: assertion failed");

`else

`define FCT_ASSERT_IMPL(name, ante, cons)
`define FCT_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- hw/rtl/fct_pkg.sv -----
// ---------------------------------------------------------------------------
// fct_pkg - frustum culling package
// Field widths, command, verdict and kind codes, and pipeline structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fct_pkg;

  localparam int FIELD_W   = 32;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 3;
  localparam int RADIUS_W  = 31;
  localparam int VERDICT_W = 2;
  localparam int KIND_W    = 2;
  localparam int FRAC_BITS = 16;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [VERDICT_W-1:0] verdict_t;
  typedef logic [KIND_W-1:0]    kind_t;

  localparam cmd_t CMD_LOAD   = 2'd0;
  localparam cmd_t CMD_POINT  = 2'd1;
  localparam cmd_t CMD_SPHERE = 2'd2;
  localparam cmd_t CMD_VERTEX = 2'd3;

  localparam verdict_t VERDICT_INSIDE    = 2'd0;
  localparam verdict_t VERDICT_INTERSECT = 2'd1;
  localparam verdict_t VERDICT_OUTSIDE   = 2'd2;

  localparam kind_t KIND_POINT   = 2'd0;
  localparam kind_t KIND_SPHERE  = 2'd1;
  localparam kind_t KIND_POLYGON = 2'd2;

  // Control that travels with a test item down the pipeline.
  typedef struct packed {
    logic                valid;
    cmd_t                cmd;
    logic                last;
    logic [RADIUS_W-1:0] radius;
  } stage_ctl_t;

  // Per-plane comparison outcome.
  typedef struct packed {
    logic neg;          // distance < 0
    logic below_neg_r;  // distance < -radius
    logic below_r;      // distance < radius
  } lane_flags_t;

endpackage

// ----- hw/rtl/fct_in_if.sv -----
// ---------------------------------------------------------------------------
// fct_in_if - command and test item channel
// Valid/ready channel carrying one load, point, sphere or vertex item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fct_in_if;
  import fct_pkg::*;

  logic                       valid;
  logic                       ready;
  cmd_t                       command;
  logic [IDX_W-1:0]           plane_index;
  logic signed [FIELD_W-1:0]  normal_x;
  logic signed [FIELD_W-1:0]  normal_y;
  logic signed [FIELD_W-1:0]  normal_z;
  logic signed [FIELD_W-1:0]  offset_d;
  logic signed [FIELD_W-1:0]  pos_x;
  logic signed [FIELD_W-1:0]  pos_y;
  logic signed [FIELD_W-1:0]  pos_z;
  logic [RADIUS_W-1:0]        radius;
  logic                       last_vertex;

  modport source (
    output valid, command, plane_index, normal_x, normal_y, normal_z, offset_d,
           pos_x, pos_y, pos_z, radius, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, command, plane_index, normal_x, normal_y, normal_z, offset_d,
           pos_x, pos_y, pos_z, radius, last_vertex,
    output ready
  );
endinterface

// ----- hw/rtl/fct_out_if.sv -----
// ---------------------------------------------------------------------------
// fct_out_if - result channel
// Valid/ready channel carrying one verdict item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fct_out_if;
  import fct_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;
  kind_t    test_kind;

  modport source (output valid, verdict, test_kind, input ready);
  modport sink   (input valid, verdict, test_kind, output ready);
endinterface

// ----- hw/rtl/fct_plane_regs.sv -----
// ---------------------------------------------------------------------------
// fct_plane_regs - frustum plane store
// One register set per plane, written by load items, read in parallel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fct_plane_regs #(
  parameter int NP = 6,
  parameter int C  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        we,
  input  logic [fct_pkg::IDX_W-1:0]   index,
  input  logic signed [C-1:0]         wr_nx,
  input  logic signed [C-1:0]         wr_ny,
  input  logic signed [C-1:0]         wr_nz,
  input  logic signed [C-1:0]         wr_off,
  output logic signed [C-1:0]         nx  [NP],
  output logic signed [C-1:0]         ny  [NP],
  output logic signed [C-1:0]         nz  [NP],
  output logic signed [C-1:0]         off [NP]
);
  import fct_pkg::*;

  // An index at or beyond NP matches no plane, so the load is dropped.
  always_ff @(posedge clk) begin
    for (int p = 0; p < NP; p++) begin
      if (rst) begin
        nx[p]  <= '0;
        ny[p]  <= '0;
        nz[p]  <= '0;
        off[p] <= '0;
      end else if (we && index == IDX_W'(p)) begin
        nx[p]  <= wr_nx;
        ny[p]  <= wr_ny;
        nz[p]  <= wr_nz;
        off[p] <= wr_off;
      end
    end
  end

endmodule

// ----- hw/rtl/fct_plane_lane.sv -----
// ---------------------------------------------------------------------------
// fct_plane_lane - distance lane for one plane
// Registers the three products, then sums the distance and compares it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fct_plane_lane #(
  parameter int C = 32
) (
  input  logic                           clk,
  input  logic                           capture,
  input  logic signed [C-1:0]            nx,
  input  logic signed [C-1:0]            ny,
  input  logic signed [C-1:0]            nz,
  input  logic signed [C-1:0]            off,
  input  logic signed [C-1:0]            px,
  input  logic signed [C-1:0]            py,
  input  logic signed [C-1:0]            pz,
  input  logic [fct_pkg::RADIUS_W-1:0]   radius,
  output fct_pkg::lane_flags_t           flags
);
  import fct_pkg::*;

  localparam int PW = 2 * C;
  // Room for the exact Q32.32 sum and for +/- radius on top of it.
  localparam int DW = (2 * C + 3 > 49) ? 2 * C + 3 : 49;

  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;
  logic signed [PW-1:0] prod_z;
  logic signed [C-1:0]  off_q;

  logic signed [DW-1:0] distance;
  logic signed [DW-1:0] r_fix;
  logic signed [DW-1:0] dist_plus_r;
  logic signed [DW-1:0] dist_minus_r;

  always_ff @(posedge clk) begin
    if (capture) begin
      prod_x <= nx * px;
      prod_y <= ny * py;
      prod_z <= nz * pz;
      off_q  <= off;
    end
  end

  always_comb begin
    distance = (DW'(off_q) <<< FRAC_BITS) + DW'(prod_x) + DW'(prod_y) + DW'(prod_z);
    r_fix        = signed'(DW'({radius, {FRAC_BITS{1'b0}}}));
    dist_plus_r  = distance + r_fix;
    dist_minus_r = distance - r_fix;
    flags.neg         = distance[DW-1];
    flags.below_neg_r = dist_plus_r[DW-1];
    flags.below_r     = dist_minus_r[DW-1];
  end

endmodule

// ----- hw/rtl/fct_verdict.sv -----
// ---------------------------------------------------------------------------
// fct_verdict - verdict and polygon gathering stage
// Folds the plane flags into a verdict and holds it in the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "frustum_cull_test_assert.svh"

module fct_verdict #(
  parameter int NP = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fct_pkg::stage_ctl_t   ctl,
  input  fct_pkg::lane_flags_t  flags [NP],
  output logic                  advance,
  fct_out_if.source             result_out
);
  import fct_pkg::*;

  localparam logic [NP-1:0] PLANE_ALL = {NP{1'b1}};

  logic [NP-1:0] neg_v;
  logic [NP-1:0] below_neg_r_v;
  logic [NP-1:0] below_r_v;
  logic [NP-1:0] any_in;
  logic [NP-1:0] any_out;
  logic [NP-1:0] any_in_next;
  logic [NP-1:0] any_out_next;
  logic          out_free;
  logic          gives_result;
  logic          vertex_update;
  verdict_t      verdict_next;
  kind_t         kind_next;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      neg_v[p]         = flags[p].neg;
      below_neg_r_v[p] = flags[p].below_neg_r;
      below_r_v[p]     = flags[p].below_r;
    end
  end

  assign out_free      = !result_out.valid || result_out.ready;
  assign advance       = !ctl.valid || out_free;
  assign vertex_update = ctl.valid && out_free && ctl.cmd == CMD_VERTEX;
  assign gives_result  = ctl.valid && ctl.cmd != CMD_LOAD &&
                         (ctl.cmd != CMD_VERTEX || ctl.last);
  assign any_in_next   = any_in | ~neg_v;
  assign any_out_next  = any_out | neg_v;

  always_comb begin
    verdict_next = VERDICT_INSIDE;
    kind_next    = KIND_POLYGON;
    case (ctl.cmd)
      CMD_POINT: begin
        kind_next = KIND_POINT;
        if (|neg_v) verdict_next = VERDICT_OUTSIDE;
      end
      CMD_SPHERE: begin
        kind_next = KIND_SPHERE;
        if (|below_neg_r_v)  verdict_next = VERDICT_OUTSIDE;
        else if (|below_r_v) verdict_next = VERDICT_INTERSECT;
      end
      default: begin
        if (any_in_next != PLANE_ALL) verdict_next = VERDICT_OUTSIDE;
        else if (|any_out_next)       verdict_next = VERDICT_INTERSECT;
      end
    endcase
  end

  // Gather per-plane flags; clear them once the last vertex has reported.
  always_ff @(posedge clk) begin
    if (rst) begin
      any_in  <= '0;
      any_out <= '0;
    end else if (vertex_update) begin
      if (ctl.last) begin
        any_in  <= '0;
        any_out <= '0;
      end else begin
        any_in  <= any_in_next;
        any_out <= any_out_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (out_free) begin
      result_out.valid <= gives_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && gives_result) begin
      result_out.verdict   <= verdict_next;
      result_out.test_kind <= kind_next;
    end
  end

  `FCT_ASSERT_NEXT(a_flags_clear, vertex_update && ctl.last, any_in == '0 && any_out == '0)
  `FCT_ASSERT_NEXT(a_flags_cover, vertex_update && !ctl.last, (any_in | any_out) == PLANE_ALL)
  `FCT_ASSERT_IMPL(a_point_no_isect, result_out.valid && result_out.test_kind == KIND_POINT, result_out.verdict != VERDICT_INTERSECT)

endmodule

// ----- hw/rtl/frustum_cull_test.sv -----
// ---------------------------------------------------------------------------
// frustum_cull_test - six-plane view-frustum culling
// Holds the frustum planes and classifies points, spheres and polygons.
// ---------------------------------------------------------------------------
// Channel     Dir  Carries
// item_in     in   command, plane_index, normal_x/y/z, offset_d, pos_x/y/z,
//                  radius, last_vertex
// result_out  out  verdict, test_kind
//
// One item per cycle while result_out is not stalled. A test item passes through
// the input register, then the product register (one multiplier per normal
// component per plane), then the distance sum and compare feeding the result
// register, whose output is result_out. Loads write the plane store at
// acceptance and give no result; a vertex that is not the last gives none.
// Reset (rst, synchronous) zeroes all planes and the polygon flags, and
// empties the pipeline. A stall on result_out backs up stage by stage, so
// item_in drops ready only once all three stages hold an item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "frustum_cull_test_assert.svh"

module frustum_cull_test #(
  parameter int NUM_PLANES = 6,
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  fct_in_if.sink      item_in,
  fct_out_if.source   result_out
);
  import fct_pkg::*;

  // Input stage
  stage_ctl_t                   s1_ctl;
  logic signed [COORD_BITS-1:0] px_q;
  logic signed [COORD_BITS-1:0] py_q;
  logic signed [COORD_BITS-1:0] pz_q;
  // Product stage control (products themselves live in the lanes)
  stage_ctl_t                   s2_ctl;

  logic accept;
  logic in_adv;
  logic prod_adv;
  logic load_we;

  logic signed [COORD_BITS-1:0] pl_nx  [NUM_PLANES];
  logic signed [COORD_BITS-1:0] pl_ny  [NUM_PLANES];
  logic signed [COORD_BITS-1:0] pl_nz  [NUM_PLANES];
  logic signed [COORD_BITS-1:0] pl_off [NUM_PLANES];
  lane_flags_t                  lane_flags [NUM_PLANES];

  // The input stage moves on when empty or when the product stage takes it.
  assign in_adv        = !s1_ctl.valid || prod_adv;
  assign item_in.ready = in_adv;
  assign accept        = item_in.valid && in_adv;
  assign load_we       = accept && item_in.command == CMD_LOAD;

  // Planes: a load lands at acceptance, so a test accepted later sees it and
  // a test already in flight has captured its products from the old plane.
  fct_plane_regs #(
    .NP (NUM_PLANES),
    .C  (COORD_BITS)
  ) u_planes (
    .clk    (clk),
    .rst    (rst),
    .we     (load_we),
    .index  (item_in.plane_index),
    .wr_nx  (item_in.normal_x[COORD_BITS-1:0]),
    .wr_ny  (item_in.normal_y[COORD_BITS-1:0]),
    .wr_nz  (item_in.normal_z[COORD_BITS-1:0]),
    .wr_off (item_in.offset_d[COORD_BITS-1:0]),
    .nx     (pl_nx),
    .ny     (pl_ny),
    .nz     (pl_nz),
    .off    (pl_off)
  );

  // Input register: hold test items only, drop loads here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (in_adv) begin
      s1_ctl.valid  <= accept && item_in.command != CMD_LOAD;
      s1_ctl.cmd    <= item_in.command;
      s1_ctl.last   <= item_in.last_vertex;
      s1_ctl.radius <= item_in.radius;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      px_q <= item_in.pos_x[COORD_BITS-1:0];
      py_q <= item_in.pos_y[COORD_BITS-1:0];
      pz_q <= item_in.pos_z[COORD_BITS-1:0];
    end
  end

  // Product stage control: advance in step with the lanes' product registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (prod_adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  // One lane per plane, all evaluated in parallel.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fct_plane_lane #(
      .C (COORD_BITS)
    ) u_lane (
      .clk     (clk),
      .capture (prod_adv),
      .nx      (pl_nx[p]),
      .ny      (pl_ny[p]),
      .nz      (pl_nz[p]),
      .off     (pl_off[p]),
      .px      (px_q),
      .py      (py_q),
      .pz      (pz_q),
      .radius  (s2_ctl.radius),
      .flags   (lane_flags[p])
    );
  end

  // Verdict, polygon flags and the result register.
  fct_verdict #(
    .NP (NUM_PLANES)
  ) u_verdict (
    .clk        (clk),
    .rst        (rst),
    .ctl        (s2_ctl),
    .flags      (lane_flags),
    .advance    (prod_adv),
    .result_out (result_out)
  );

  // Ready may only fall when every stage is occupied and the result is stuck.
  `FCT_ASSERT_IMPL(a_stall_full, !item_in.ready, s1_ctl.valid && s2_ctl.valid && result_out.valid && !result_out.ready)

endmodule
